>>> sv/fcpr_pkg.sv
`default_nettype none
package fcpr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 16;
    localparam logic [7:0]  HDR1            = 8'hAA;
    localparam logic [7:0]  HDR2            = 8'h55;
    localparam logic [7:0]  OWN_ADDR_RST    = 8'd1;
    localparam logic [15:0] TIMEOUT_RST     = 16'd100;
    localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

    localparam logic        CMD_BYTE        = 1'b0;
    localparam logic        CMD_TICK        = 1'b1;
    localparam logic        KIND_PACKET     = 1'b0;
    localparam logic        KIND_RESEND     = 1'b1;

    localparam int unsigned APB_ADDR_W      = 3;
    localparam logic        REG_OWN_ADDR    = 1'b0;
    localparam logic        REG_TIMEOUT     = 1'b1;

    typedef enum logic [6:0] {
        F_HDR1 = 7'b0000001,
        F_HDR2 = 7'b0000010,
        F_ADDR = 7'b0000100,
        F_CMD  = 7'b0001000,
        F_LEN  = 7'b0010000,
        F_DATA = 7'b0100000,
        F_SUM  = 7'b1000000
    } t_frame_state;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_READ = 3'b010,
        D_LOAD = 3'b100
    } t_drain_state;

    typedef struct packed {
        logic       start;
        logic       kind;
        logic [7:0] cmd;
        logic [7:0] len;
    } t_run;

endpackage
`default_nettype wire

>>> sv/fcpr_if.sv
`default_nettype none
interface fcpr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface fcpr_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] command_code;
    logic [4:0] data_length;
    logic [3:0] data_index;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output command_code, output data_length,
                    output data_index, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input command_code, input data_length,
                    input data_index, input data_byte, input last, output ready);
endinterface
`default_nettype wire

>>> sv/fcpr_payload_mem.sv
`default_nettype none
module fcpr_payload_mem #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> sv/fcpr_framer.sv
`default_nettype none
module fcpr_framer #(
    parameter int unsigned MAX_PAYLOAD = 16,
    parameter int unsigned IDX_W       = 4,
    parameter int unsigned CNT_W       = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_command,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic [7:0]         i_own_address,
    input  wire logic [15:0]        i_timeout_ms,
    output logic                    o_wr_en,
    output logic      [IDX_W-1:0]   o_wr_addr,
    output logic      [7:0]         o_wr_data,
    output fcpr_pkg::t_run          o_run
);
    import fcpr_pkg::*;

    t_frame_state r_state, n_state;
    logic [15:0]  r_elapsed, n_elapsed;
    logic [7:0]   r_addr, n_addr;
    logic [7:0]   r_sum, n_sum;
    logic [7:0]   r_cmd, n_cmd;
    logic [7:0]   r_len, n_len;
    logic [CNT_W-1:0] r_fill, n_fill;
    t_frame_state cur_state;
    logic [7:0]   sum_plus;

    always_comb begin
        n_state   = r_state;
        n_elapsed = r_elapsed;
        n_addr    = r_addr;
        n_sum     = r_sum;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_fill    = r_fill;
        o_wr_en   = 1'b0;
        o_wr_addr = r_fill[IDX_W-1:0];
        o_wr_data = i_rx_byte;
        o_run     = '0;
        sum_plus  = r_sum + i_rx_byte;
        cur_state = (r_elapsed >= i_timeout_ms) ? F_HDR1 : r_state;
        if (i_accept && i_command == CMD_TICK) begin
            if (r_elapsed != TICKS_MAX) begin
                n_elapsed = r_elapsed + 16'd1;
            end
        end else if (i_accept) begin
            n_state = F_HDR1;
            case (cur_state)
                F_HDR1: begin
                    if (i_rx_byte == HDR1) begin
                        n_elapsed = '0;
                        n_state   = F_HDR2;
                    end
                end
                F_HDR2: begin
                    if (i_rx_byte == HDR2) begin
                        n_state = F_ADDR;
                    end
                end
                F_ADDR: begin
                    if (i_rx_byte != 8'd0) begin
                        n_addr  = i_rx_byte;
                        n_sum   = i_rx_byte;
                        n_state = F_CMD;
                    end
                end
                F_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_sum   = sum_plus;
                    n_state = F_LEN;
                end
                F_LEN: begin
                    n_sum  = sum_plus;
                    n_fill = '0;
                    if (i_rx_byte == 8'd0) begin
                        n_len   = '0;
                        n_state = F_SUM;
                    end else if (i_rx_byte <= 8'(MAX_PAYLOAD)) begin
                        n_len   = i_rx_byte;
                        n_state = F_DATA;
                    end
                end
                F_DATA: begin
                    o_wr_en = 1'b1;
                    n_fill  = r_fill + 1'b1;
                    n_sum   = sum_plus;
                    n_state = (8'(n_fill) >= r_len) ? F_SUM : F_DATA;
                end
                F_SUM: begin
                    if (i_rx_byte == r_sum) begin
                        if (r_addr == i_own_address) begin
                            o_run.start = 1'b1;
                            o_run.kind  = KIND_PACKET;
                            o_run.cmd   = r_cmd;
                            o_run.len   = r_len;
                        end
                    end else begin
                        o_run.start = 1'b1;
                        o_run.kind  = KIND_RESEND;
                    end
                end
                default: begin
                    n_state = F_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_HDR1;
            r_elapsed <= '0;
            r_addr    <= '0;
            r_sum     <= '0;
            r_cmd     <= '0;
            r_len     <= '0;
            r_fill    <= '0;
        end else begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_addr    <= n_addr;
            r_sum     <= n_sum;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_fill    <= n_fill;
        end
    end

endmodule
`default_nettype wire

>>> sv/fcpr_drain.sv
`default_nettype none
module fcpr_drain #(
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fcpr_pkg::t_run   i_run,
    input  wire logic [7:0]       i_rd_data,
    output logic                  o_rd_en,
    output logic      [IDX_W-1:0] o_rd_addr,
    output logic                  o_idle,
    fcpr_out_if.source            o_out
);
    import fcpr_pkg::*;

    t_drain_state     r_state, n_state;
    t_run             r_run, n_run;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic             r_kind, n_kind;
    logic [7:0]       r_cmd, n_cmd;
    logic [4:0]       r_len, n_len;
    logic [3:0]       r_didx, n_didx;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic             out_free;
    logic             len_zero;
    logic             word_last;

    assign out_free  = !r_valid || o_out.ready;
    assign len_zero  = (r_run.len == 8'd0);
    assign word_last = (r_run.kind == KIND_RESEND) || len_zero
                       || ((8'(r_idx) + 8'd1) == r_run.len);
    assign o_idle    = (r_state == D_IDLE);
    assign o_rd_en   = (r_state == D_READ);
    assign o_rd_addr = r_idx[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        n_idx   = r_idx;
        n_valid = r_valid && !o_out.ready;
        n_kind  = r_kind;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_didx  = r_didx;
        n_byte  = r_byte;
        n_last  = r_last;
        case (r_state)
            D_IDLE: begin
                if (i_run.start) begin
                    n_run   = i_run;
                    n_idx   = '0;
                    n_state = D_READ;
                end
            end
            D_READ: begin
                n_state = D_LOAD;
            end
            D_LOAD: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_kind  = r_run.kind;
                    n_last  = word_last;
                    if (r_run.kind == KIND_RESEND) begin
                        n_cmd  = '0;
                        n_len  = '0;
                        n_didx = '0;
                        n_byte = '0;
                    end else begin
                        n_cmd  = r_run.cmd;
                        n_len  = 5'(r_run.len);
                        n_didx = 4'(r_idx);
                        n_byte = len_zero ? 8'd0 : i_rd_data;
                    end
                    if (word_last) begin
                        n_state = D_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = D_READ;
                    end
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run  <= n_run;
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_cmd  <= n_cmd;
        r_len  <= n_len;
        r_didx <= n_didx;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_kind;
    assign o_out.command_code = r_cmd;
    assign o_out.data_length  = r_len;
    assign o_out.data_index   = r_didx;
    assign o_out.data_byte    = r_byte;
    assign o_out.last         = r_last;

endmodule
`default_nettype wire

>>> sv/framed_command_packet_receiver.sv
// Receives framed command packets (0xAA, 0x55, address, command, length, up to MAX_PAYLOAD
// data bytes, additive checksum) from a stream of words that each carry either a received
// byte or a one millisecond tick. Payload bytes are written to a payload memory with one
// write and one read port as they arrive. The checksum byte of a good packet for this
// address starts a run of one result per payload byte (one result for an empty payload); a
// bad checksum gives one resend request. For each result of a run the drain first reads the
// payload memory and then loads the output register, waiting while the output is stalled,
// and the input is held off until the run's last result is in the output register.
// own_address lies at byte address 0 and timeout_ms at byte address 4 of the APB port.
`default_nettype none
module framed_command_packet_receiver
    import fcpr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = fcpr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    fcpr_in_if.sink                              i_in,
    fcpr_out_if.source                           o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fcpr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]  r_own_address;
    logic [15:0] r_timeout_ms;
    logic        drain_idle;
    logic        in_accept;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]  rd_data;
    t_run        run;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout_ms}
                                                 : {24'd0, r_own_address};
    assign i_in.ready = drain_idle;
    assign in_accept  = i_in.valid && drain_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDR_RST;
            r_timeout_ms  <= TIMEOUT_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_OWN_ADDR) begin
                r_own_address <= pwdata[7:0];
            end else begin
                r_timeout_ms <= pwdata[15:0];
            end
        end
    end

    fcpr_framer #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_command     (i_in.command),
        .i_rx_byte     (i_in.rx_byte),
        .i_own_address (r_own_address),
        .i_timeout_ms  (r_timeout_ms),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_run         (run)
    );

    fcpr_payload_mem #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fcpr_drain #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_drain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_run     (run),
        .i_rd_data (rd_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_idle    (drain_idle),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

>>> sv/fcpr_checker.sv
`default_nettype none
module fcpr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_kind,
    input wire logic [7:0] i_out_command_code,
    input wire logic [4:0] i_out_data_length,
    input wire logic [3:0] i_out_data_index,
    input wire logic [7:0] i_out_data_byte,
    input wire logic       i_out_last
);
    import fcpr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_out_data_byte) && $stable(i_out_last) && $stable(i_out_kind))
        else $error("Output word changed while stalled.");

    a_resend_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_RESEND |-> i_out_last
            && i_out_command_code == 8'd0 && i_out_data_length == 5'd0
            && i_out_data_index == 4'd0 && i_out_data_byte == 8'd0)
        else $error("Malformed resend request.");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_PACKET && i_out_data_length == 5'd0
            |-> i_out_last && i_out_data_index == 4'd0 && i_out_data_byte == 8'd0)
        else $error("Malformed empty packet result.");

    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("Input taken in the middle of a run.");

endmodule

bind framed_command_packet_receiver fcpr_checker u_fcpr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_kind         (o_out.kind),
    .i_out_command_code (o_out.command_code),
    .i_out_data_length  (o_out.data_length),
    .i_out_data_index   (o_out.data_index),
    .i_out_data_byte    (o_out.data_byte),
    .i_out_last         (o_out.last)
);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

import fcpr_pkg::*;

typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [4:0] length;
    logic [3:0] index;
    logic [7:0] data;
    logic       last;
} t_rx_result;

class frame_checker;
    logic [7:0]   own_addr;
    logic [15:0]  abandon_ticks;
    t_frame_state fstate;
    logic [15:0]  ticks;
    logic [7:0]   addr;
    logic [7:0]   sum;
    logic [7:0]   code;
    logic [4:0]   length;
    logic [4:0]   fill;
    logic [7:0]   payload [MAX_PAYLOAD_DEF];
    t_rx_result   due_results [$];
    int           errors;

    function new();
        own_addr      = OWN_ADDR_RST;
        abandon_ticks = TIMEOUT_RST;
        fstate        = F_HDR1;
        ticks         = '0;
        addr          = '0;
        sum           = '0;
        code          = '0;
        length        = '0;
        fill          = '0;
        errors        = 0;
    endfunction

    function void set_reg(logic index, logic [31:0] value);
        if (index == REG_OWN_ADDR) begin
            own_addr = value[7:0];
        end else begin
            abandon_ticks = value[15:0];
        end
    endfunction

    function void deframe_word(logic command, logic [7:0] value);
        t_rx_result r;
        if (command == CMD_TICK) begin
            if (ticks != TICKS_MAX) ticks++;
            return;
        end
        if (ticks >= abandon_ticks) fstate = F_HDR1;
        case (fstate)
            F_HDR1: begin
                if (value == HDR1) begin
                    ticks  = '0;
                    fstate = F_HDR2;
                end
            end
            F_HDR2: begin
                fstate = (value == HDR2) ? F_ADDR : F_HDR1;
            end
            F_ADDR: begin
                if (value != 8'h00) begin
                    addr   = value;
                    sum    = value;
                    fstate = F_CMD;
                end else begin
                    fstate = F_HDR1;
                end
            end
            F_CMD: begin
                code   = value;
                sum    = sum + value;
                fstate = F_LEN;
            end
            F_LEN: begin
                sum  = sum + value;
                fill = '0;
                if (value == 8'h00) begin
                    length = '0;
                    fstate = F_SUM;
                end else if (value <= MAX_PAYLOAD_DEF) begin
                    length = value[4:0];
                    fstate = F_DATA;
                end else begin
                    fstate = F_HDR1;
                end
            end
            F_DATA: begin
                if (fill < MAX_PAYLOAD_DEF) payload[fill[3:0]] = value;
                fill = fill + 5'd1;
                sum  = sum + value;
                if (fill >= length) fstate = F_SUM;
            end
            F_SUM: begin
                if (value == sum) begin
                    if (addr == own_addr) begin
                        if (length == 0) begin
                            r = '{KIND_PACKET, code, 5'd0, 4'd0, 8'h00, 1'b1};
                            due_results.push_back(r);
                        end else begin
                            for (int i = 0; i < length; i++) begin
                                r = '{KIND_PACKET, code, length, i[3:0], payload[i],
                                      (i + 1 == length)};
                                due_results.push_back(r);
                            end
                        end
                    end
                end else begin
                    r = '{KIND_RESEND, 8'h00, 5'd0, 4'd0, 8'h00, 1'b1};
                    due_results.push_back(r);
                end
                fstate = F_HDR1;
            end
            default: begin
                fstate = F_HDR1;
            end
        endcase
    endfunction

    function void check_result(t_rx_result seen);
        t_rx_result want;
        if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected result: kind %0d cmd %02h len %0d idx %0d byte %02h last %0d",
                         seen.kind, seen.code, seen.length, seen.index, seen.data, seen.last);
            end
            return;
        end
        want = due_results.pop_front();
        if (seen.kind !== want.kind || seen.code !== want.code ||
            seen.length !== want.length || seen.index !== want.index ||
            seen.data !== want.data || seen.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: expected kind %0d cmd %02h len %0d idx %0d byte %02h last %0d",
                         want.kind, want.code, want.length, want.index, want.data, want.last);
                $display("          got      kind %0d cmd %02h len %0d idx %0d byte %02h last %0d",
                         seen.kind, seen.code, seen.length, seen.index, seen.data, seen.last);
            end
        end
    endfunction
endclass

module tb;
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    fcpr_in_if  in_if ();
    fcpr_out_if out_if ();

    frame_checker board;
    t_rx_result   seen;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           words_sent;

    framed_command_packet_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.kind   = out_if.kind;
            seen.code   = out_if.command_code;
            seen.length = out_if.data_length;
            seen.index  = out_if.data_index;
            seen.data   = out_if.data_byte;
            seen.last   = out_if.last;
            board.check_result(seen);
        end
    end

    task automatic send_word(input logic command, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= command;
        in_if.rx_byte <= value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.deframe_word(command, value);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value, input int tick_pct);
        if ($urandom_range(99) < tick_pct) send_word(CMD_TICK, 8'($urandom_range(255)));
        send_word(CMD_BYTE, value);
    endtask

    task automatic send_packet(input logic [7:0] addr, input logic [7:0] code,
                               input logic [7:0] count, input bit corrupt,
                               input int tick_pct);
        logic [7:0] sum;
        logic [7:0] value;
        sum = addr + code + count;
        send_byte(HDR1, tick_pct);
        send_byte(HDR2, tick_pct);
        send_byte(addr, tick_pct);
        if (addr == 8'h00) return;
        send_byte(code, tick_pct);
        send_byte(count, tick_pct);
        if (count > MAX_PAYLOAD_DEF) return;
        for (int i = 0; i < count; i++) begin
            value = 8'($urandom_range(255));
            sum   = sum + value;
            send_byte(value, tick_pct);
        end
        value = 8'($urandom_range(1, 255));
        send_byte(sum ^ (corrupt ? value : 8'h00), tick_pct);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_reg(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int upto);
        int         pick;
        int         lpick;
        logic [7:0] addr;
        logic [7:0] count;
        while (words_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                addr  = ($urandom_range(99) < 75) ? board.own_addr : 8'($urandom_range(1, 255));
                lpick = $urandom_range(99);
                if (lpick < 60) begin
                    count = 8'($urandom_range(0, 4));
                end else if (lpick < 80) begin
                    count = 8'($urandom_range(5, 15));
                end else begin
                    count = 8'(MAX_PAYLOAD_DEF);
                end
                send_packet(addr, 8'($urandom_range(255)), count,
                            $urandom_range(99) < 15, 3);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(($urandom_range(99) < 30) ? CMD_TICK : CMD_BYTE,
                              8'($urandom_range(255)));
                end
            end else if (pick < 90) begin
                if ($urandom_range(1) == 0) begin
                    send_packet(8'h00, 8'h00, 8'h00, 1'b0, 3);
                end else begin
                    send_packet(board.own_addr, 8'($urandom_range(255)),
                                8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 1'b0, 3);
                end
            end else begin
                send_byte(HDR1, 3);
                send_byte(HDR2, 3);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(255)), 3);
            end
        end
    endtask

    initial begin
        board         = new();
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.command = CMD_BYTE;
        in_if.rx_byte = 8'h00;
        out_if.ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        words_sent    = 0;
        send_idle_pct = 26;
        recv_idle_pct = 46;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_TICK, 8'hFF);
        send_packet(8'h01, 8'hFF, 8'h00, 1'b0, 0);
        send_packet(8'h07, 8'h00, 8'h00, 1'b1, 0);
        send_packet(8'h00, 8'h00, 8'h00, 1'b0, 0);
        send_packet(8'h01, 8'h12, 8'd17, 1'b0, 0);
        send_packet(8'h02, 8'h33, 8'h00, 1'b0, 0);
        settle();

        write_reg(REG_OWN_ADDR, 32'hFF);
        write_reg(REG_TIMEOUT, 32'd1);
        send_word(CMD_BYTE, HDR1);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_BYTE, HDR2);
        send_word(CMD_BYTE, 8'hFF);
        send_word(CMD_BYTE, 8'h10);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'h0F);
        random_traffic(words_sent + 80);
        settle();

        send_idle_pct = 46;
        recv_idle_pct = 26;
        write_reg(REG_OWN_ADDR, 32'($urandom_range(2, 254)));
        write_reg(REG_TIMEOUT, 32'($urandom_range(2, 40)));
        random_traffic(words_sent + 80);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_OWN_ADDR, 32'(OWN_ADDR_RST));
        write_reg(REG_TIMEOUT, 32'(TICKS_MAX));
        send_word(CMD_BYTE, HDR1);
        repeat (20) send_word(CMD_TICK, 8'($urandom_range(255)));
        send_word(CMD_BYTE, HDR2);
        send_word(CMD_BYTE, 8'h01);
        send_word(CMD_BYTE, 8'h5A);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'h5B);
        settle();

        write_reg(REG_TIMEOUT, 32'd0);
        send_packet(8'h01, 8'h44, 8'h00, 1'b0, 0);
        settle();

        write_reg(REG_TIMEOUT, 32'(TIMEOUT_RST));
        random_traffic(words_sent + 80);
        settle();
        repeat (40) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
